// ----- hdl/wpc_pkg.sv -----
// shared types, constants and helper functions of the waypoint pid controller
// no dependencies
`default_nettype none

package wpc_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int REG_W = 31;
  localparam int DATA_W = 32;

  localparam logic [63:0] PI48 = 64'h0003_243F_6A88_85A3;

  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_P        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_D        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_I        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUARE_SIDE   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DISTANCE_TOL  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE_TOL     = 3'd6;

  localparam logic [REG_W-1:0] TIME_STEP_RST    = 31'd655;
  localparam logic [REG_W-1:0] SQUARE_SIDE_RST  = 31'd131072;
  localparam logic [REG_W-1:0] DISTANCE_TOL_RST = 31'd655;
  localparam logic [REG_W-1:0] ANGLE_TOL_RST    = 31'd66;

  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_WRAP,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_DER,
    S_INT,
    S_PID,
    S_FIN
  } wpc_state_t;

  function automatic logic signed [33:0] halfpi_mult(input logic [2:0] m, input int f);
    logic [63:0] p;
    p = 64'(m) * PI48 + (64'd1 << (48 - f));
    return 34'(p >> (49 - f));
  endfunction

  function automatic logic goal_x(input logic [PHASE_W-1:0] ph);
    return ph inside {3'd0, 3'd1, 3'd2, 3'd3};
  endfunction

  function automatic logic goal_y(input logic [PHASE_W-1:0] ph);
    return ph inside {3'd2, 3'd3, 3'd4, 3'd5};
  endfunction

  function automatic logic [1:0] goal_quarter(input logic [PHASE_W-1:0] ph);
    logic [1:0] q;
    case (ph)
      3'd1, 3'd2: q = 2'd1;
      3'd3, 3'd4: q = 2'd2;
      3'd5, 3'd6: q = 2'd3;
      default:    q = 2'd0;
    endcase
    return q;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > MAX32) begin
      r = 32'sh7FFFFFFF;
    end else if (v < MIN32) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic [31:0] r;
    r = v[31] ? 32'(-v) : 32'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/wpc_mul.sv -----
// bit-serial unsigned 32 x 32 shift-add multiplier, one bit per cycle
// no dependencies
`default_nettype none

module wpc_mul (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [63:0]      prod
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [31:0] a_r;
  logic [32:0] sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : 33'd0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi  <= '0;
      lo  <= b;
      a_r <= a;
    end else if (busy) begin
      hi <= sum[32:1];
      lo <= {sum[0], lo[31:1]};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wpc_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
// divisor is a 31-bit register value; no dependencies
`default_nettype none

module wpc_div #(
  parameter int DIVIDEND_W = 49
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [30:0]           divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [30:0]      rem;
  logic [30:0]      div_r;
  logic [31:0]      trial;
  logic             fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      div_r    <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? 31'(trial - {1'b0, div_r}) : trial[30:0];
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/wpc_sqrt.sv -----
// digit-serial integer square root, two radicand bits per cycle
// no dependencies
`default_nettype none

module wpc_sqrt (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             done,
  output logic [31:0]      root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] nr;
  logic [33:0] rem;
  logic [35:0] t;
  logic [35:0] trial;
  logic        fits;

  assign t     = {rem, nr[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign fits  = t >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nr   <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      nr   <= {nr[61:0], 2'b00};
      rem  <= fits ? 34'(t - trial) : t[33:0];
      root <= {root[30:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/waypoint_pid_controller.sv -----
// square path waypoint follower with shared-gain distance and heading pid loops
// uses wpc_pkg, wpc_mul, wpc_div, wpc_sqrt
// One pose sample is taken at a time and occupies the block from one input transfer
// to the next. The work is done by the bit-serial units: two squarings, a square root,
// eight multiplies and two divides (the divides are skipped when time_step is 0), all
// issued one after the other by a single sequencer, between the accept, setup and
// commit steps. A new sample is accepted while the previous result still waits on
// the output register.
`default_nettype none

module waypoint_pid_controller #(
  parameter int FRACTION_BITS = wpc_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [wpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [wpc_pkg::REG_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic signed [31:0]              pos_x,
  input  wire logic signed [31:0]              pos_y,
  input  wire logic signed [31:0]              heading,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [31:0]                   linear_cmd,
  output logic signed [31:0]                   angular_cmd,
  output logic signed [31:0]                   distance_error,
  output logic signed [31:0]                   heading_error,
  output logic [wpc_pkg::PHASE_W-1:0]          phase_used,
  output logic                                 advanced
);

  import wpc_pkg::*;

  localparam int DIV_W = 33 + FRACTION_BITS;
  localparam logic signed [33:0] GTH1   = halfpi_mult(3'd1, FRACTION_BITS);
  localparam logic signed [33:0] GTH2   = halfpi_mult(3'd2, FRACTION_BITS);
  localparam logic signed [33:0] GTH3   = halfpi_mult(3'd3, FRACTION_BITS);
  localparam logic signed [33:0] TWO_PI = halfpi_mult(3'd4, FRACTION_BITS);

  wpc_state_t state, state_next;

  logic [REG_W-1:0] gain_p, gain_d, gain_i, time_step, square_side;
  logic [REG_W-1:0] distance_tol, angle_tol;

  logic [PHASE_W-1:0] phase;
  logic signed [31:0] last_de, last_he, dist_int, head_int;

  logic signed [31:0] x, y, th;
  logic signed [33:0] dx, dy, eth_raw;
  logic [32:0]        adx, ady;
  logic               big, ovs;
  logic [63:0]        sq;
  logic signed [31:0] ed, eth, dd, dth, lin, ang;
  logic signed [63:0] acc;
  logic               run, sel;
  logic [1:0]         term;

  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        div_start, div_done;
  logic [DIV_W-1:0] div_q;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;
  logic        commit;

  logic signed [31:0] op_v;
  logic signed [63:0] shifted, term_val;
  logic signed [33:0] gth;
  logic signed [31:0] e_sel, l_sel;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [31:0]        q_c;
  logic signed [31:0] der_val;
  logic signed [33:0] eth_wrap;
  logic [31:0]        ed_mag;
  logic               adv;
  logic               dt_zero;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= '0;
      gain_d       <= '0;
      gain_i       <= '0;
      time_step    <= TIME_STEP_RST;
      square_side  <= SQUARE_SIDE_RST;
      distance_tol <= DISTANCE_TOL_RST;
      angle_tol    <= ANGLE_TOL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GAIN_P:       gain_p       <= cfg_data;
        REG_GAIN_D:       gain_d       <= cfg_data;
        REG_GAIN_I:       gain_i       <= cfg_data;
        REG_TIME_STEP:    time_step    <= cfg_data;
        REG_SQUARE_SIDE:  square_side  <= cfg_data;
        REG_DISTANCE_TOL: distance_tol <= cfg_data;
        REG_ANGLE_TOL:    angle_tol    <= cfg_data;
        default: ;
      endcase
    end
  end

  // arithmetic units
  wpc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  wpc_div #(
    .DIVIDEND_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({diff_mag, {FRACTION_BITS{1'b0}}}),
    .divisor  (time_step),
    .done     (div_done),
    .quotient (div_q)
  );

  wpc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // operand selection
  always_comb begin
    case (goal_quarter(phase))
      2'd1:    gth = GTH1;
      2'd2:    gth = GTH2;
      2'd3:    gth = GTH3;
      default: gth = '0;
    endcase

    e_sel = sel ? eth : ed;
    l_sel = sel ? last_he : last_de;
    diff  = {e_sel[31], e_sel} - {l_sel[31], l_sel};
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    case (term)
      2'd1:    op_v = sel ? dth : dd;
      2'd2:    op_v = sel ? head_int : dist_int;
      default: op_v = e_sel;
    endcase

    case (state)
      S_SQX: begin
        mul_a = adx[31:0];
        mul_b = adx[31:0];
      end
      S_SQY: begin
        mul_a = ady[31:0];
        mul_b = ady[31:0];
      end
      S_INT: begin
        mul_a = mag32(e_sel);
        mul_b = {1'b0, time_step};
      end
      default: begin
        mul_a = mag32(op_v);
        case (term)
          2'd1:    mul_b = {1'b0, gain_d};
          2'd2:    mul_b = {1'b0, gain_i};
          default: mul_b = {1'b0, gain_p};
        endcase
      end
    endcase

    shifted  = $signed(64'(mul_p >> FRACTION_BITS));
    term_val = ((state == S_INT) ? e_sel[31] : op_v[31]) ? -shifted : shifted;

    if ((|div_q[DIV_W-1:32]) || (div_q[31:0] > 32'h8000_0000)) begin
      q_c = 32'h8000_0000;
    end else begin
      q_c = div_q[31:0];
    end
    if (dt_zero) begin
      der_val = '0;
    end else if (diff[32]) begin
      der_val = $signed(32'(-q_c));
    end else begin
      der_val = q_c[31] ? 32'sh7FFFFFFF : $signed(q_c);
    end

    if (eth_raw > TWO_PI) begin
      eth_wrap = eth_raw - TWO_PI;
    end else if (eth_raw < -TWO_PI) begin
      eth_wrap = eth_raw + TWO_PI;
    end else begin
      eth_wrap = eth_raw;
    end

    ed_mag = (big || sqrt_root[31]) ? 32'h7FFF_FFFF : sqrt_root;
    adv = phase[0] ? (mag32(eth) < {1'b0, angle_tol}) : (mag32(ed) < {1'b0, distance_tol});
  end

  assign dt_zero = (time_step == '0);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_PREP;
      S_PREP: state_next = S_WRAP;
      S_WRAP: state_next = S_SQX;
      S_SQX:  if (mul_done) state_next = S_SQY;
      S_SQY:  if (mul_done) state_next = S_SQRT;
      S_SQRT: if (sqrt_done) state_next = S_DER;
      S_DER:  if (sel && (dt_zero || div_done)) state_next = S_INT;
      S_INT:  if (sel && mul_done) state_next = S_PID;
      S_PID:  if (sel && mul_done && term == 2'd2) state_next = S_FIN;
      S_FIN:  if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = (state != S_IDLE);
    mul_start  = !run && (state == S_SQX || state == S_SQY || state == S_INT ||
                          state == S_PID);
    div_start  = !run && (state == S_DER) && !dt_zero;
    sqrt_start = !run && (state == S_SQRT);
    commit     = (state == S_FIN) && (!out_valid || !out_stall);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      sel  <= 1'b0;
      term <= '0;
    end else begin
      if (mul_start || div_start || sqrt_start) begin
        run <= 1'b1;
      end else if (mul_done || div_done || sqrt_done) begin
        run <= 1'b0;
      end
      case (state)
        S_DER: if (dt_zero || div_done) sel <= !sel;
        S_INT: if (mul_done) sel <= !sel;
        S_PID: begin
          if (mul_done) begin
            if (term == 2'd2) begin
              term <= '0;
              sel  <= !sel;
            end else begin
              term <= term + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        x  <= pos_x;
        y  <= pos_y;
        th <= heading;
      end
      S_PREP: begin
        dx <= (goal_x(phase) ? $signed({3'b000, square_side}) : 34'sd0) - 34'(x);
        dy <= (goal_y(phase) ? $signed({3'b000, square_side}) : 34'sd0) - 34'(y);
        eth_raw <= gth - 34'(th);
      end
      S_WRAP: begin
        adx <= dx[33] ? 33'(-dx) : 33'(dx);
        ady <= dy[33] ? 33'(-dy) : 33'(dy);
        big <= (dx[33] ? 33'(-dx) : 33'(dx)) >= 33'h0_8000_0000 ||
               (dy[33] ? 33'(-dy) : 33'(dy)) >= 33'h0_8000_0000;
        ovs <= (phase == 3'd0 && x > $signed({1'b0, square_side})) ||
               (phase == 3'd2 && y > $signed({1'b0, square_side})) ||
               (phase == 3'd4 && x < 32'sd0) ||
               (phase == 3'd6 && y < 32'sd0);
        eth <= sat32(64'(eth_wrap));
      end
      S_SQX: if (mul_done) sq <= mul_p;
      S_SQY: if (mul_done) sq <= sq + mul_p;
      S_SQRT: if (sqrt_done) ed <= ovs ? $signed(32'(-ed_mag)) : $signed(ed_mag);
      S_DER: begin
        if (dt_zero || div_done) begin
          if (sel) dth <= der_val;
          else dd <= der_val;
        end
      end
      S_PID: begin
        if (mul_done) begin
          acc <= ((term == 2'd0) ? 64'sd0 : acc) + term_val;
          if (term == 2'd2) begin
            if (sel) ang <= sat32(acc + term_val);
            else lin <= sat32(acc + term_val);
          end
        end
      end
      default: ;
    endcase
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      last_de  <= '0;
      last_he  <= '0;
      dist_int <= '0;
      head_int <= '0;
    end else if (state == S_INT && mul_done) begin
      if (sel) head_int <= sat32(64'(head_int) + term_val);
      else dist_int <= sat32(64'(dist_int) + term_val);
    end else if (commit) begin
      last_de <= ed;
      last_he <= eth;
      if (adv) begin
        phase    <= phase + 3'd1;
        dist_int <= '0;
        head_int <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      linear_cmd     <= lin;
      angular_cmd    <= ang;
      distance_error <= ed;
      heading_error  <= eth;
      phase_used     <= phase;
      advanced       <= adv;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_PREP)
    else $error("accepted sample did not start processing");

  a_commit_loads: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("result lost at commit");

  a_phase_track: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> phase == 3'(phase_used + {2'b00, advanced}))
    else $error("phase does not follow reported advance");

  a_adv_clears: assert property (@(posedge clk) disable iff (rst)
    commit && adv |=> dist_int == 32'sd0 && head_int == 32'sd0)
    else $error("integrals not cleared on advance");

endmodule

`default_nettype wire
